// File: sv/efg_pkg.sv
package efg_pkg;

  // table size and flag word width
  localparam int WAITERS   = 8;
  localparam int FLAG_BITS = 32;

  // fixed field widths
  localparam int TASK_W    = 3;
  localparam int TASK_SPAN = 1 << TASK_W;
  localparam int DATA_W    = 32;

  // command codes on the request side
  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_WAIT    = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_t;

  // result kinds
  typedef enum logic [2:0] {
    KIND_OK      = 3'd0,
    KIND_QUEUED  = 3'd1,
    KIND_TIMEOUT = 3'd2,
    KIND_WOKEN   = 3'd3,
    KIND_NONE    = 3'd4,
    KIND_ACK     = 3'd5
  } kind_t;

  // broadcast from the controller to every waiter cell
  typedef struct packed {
    logic                 adv;
    logic                 tok_clr;
    logic                 eval;
    logic                 wr;
    logic                 drop;
    logic [FLAG_BITS-1:0] word;
    logic [FLAG_BITS-1:0] mask;
    logic                 wait_all;
    logic                 clr_done;
  } cell_ctrl_t;

endpackage

// File: sv/efg_cell.sv
module efg_cell import efg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctrl_t           ctrl,
  input  logic                 sel,
  input  logic                 tok_in,
  output logic                 tok,
  input  logic [FLAG_BITS-1:0] cmask_in,
  output logic [FLAG_BITS-1:0] cmask_out,
  input  logic                 later_in,
  output logic                 later_out,
  output logic                 busy,
  output logic                 hit,
  output logic [FLAG_BITS-1:0] rcv,
  output logic                 last
);

  logic                 valid;
  logic [FLAG_BITS-1:0] mask;
  logic                 all_bit;
  logic                 clr_bit;
  logic                 woke;
  logic [FLAG_BITS-1:0] masked;
  logic                 sat;

  // wait condition against the broadcast word
  assign masked = ctrl.word & mask;
  assign sat    = all_bit ? (masked == mask) : (|masked);

  // control state: registration, wake flag and scan token
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      woke  <= 1'b0;
      tok   <= 1'b0;
    end else begin
      if (ctrl.eval) begin
        woke <= valid && sat;
        if (valid && sat) valid <= 1'b0;
      end else if (sel && ctrl.wr) begin
        valid <= 1'b1;
      end else if (sel && ctrl.drop) begin
        valid <= 1'b0;
      end
      if (ctrl.tok_clr) begin
        tok <= 1'b0;
      end else if (ctrl.adv) begin
        tok <= tok_in;
      end
    end
  end

  // waiter payload and received bits
  always_ff @(posedge clk) begin
    if (ctrl.eval) rcv <= masked;
    if (sel && ctrl.wr) begin
      mask    <= ctrl.mask;
      all_bit <= ctrl.wait_all;
      clr_bit <= ctrl.clr_done;
    end
  end

  // neighbor chains: clear-on-exit union upward, later-woken flag downward
  assign cmask_out = cmask_in | ((woke && clr_bit) ? rcv : '0);
  assign later_out = later_in | woke;
  assign busy      = valid;
  assign hit       = tok && woke;
  assign last      = !later_in;

endmodule

// File: sv/event_flag_group.sv
// Event-flag group with one waiter slot per task, held in a row of waiter cells.
// Requests carry a command in s_tuser; clear, wait and timeout requests give a
// single result that sits in the output register the next cycle. A set request
// passes an evaluate state that checks all waiters and a clear state that clears
// the clear-on-exit bits, then a scan token walks the cell row one cell per cycle
// and emits one woken result per satisfied slot in ascending order; when nothing
// wakes, the scan is skipped. The token walk is the limit on set throughput and
// it pauses while the output register is stalled. A new request is taken only
// while no set is in progress and the output register is free or being drained.
module event_flag_group import efg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // flags[31:0], task_id[34:32], wait_all[35], clear_when_done[36], may_block[37]
  input  logic [39:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // slot[2:0], received[34:3], flags_now[66:35]
  output logic [71:0] m_tdata,
  // kind[2:0]
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CLR,
    ST_SCAN
  } state_t;

  state_t               state;
  logic [FLAG_BITS-1:0] flag_word;
  logic                 tok_start;

  logic                 out_valid;
  kind_t                out_kind;
  logic [TASK_W-1:0]    out_slot;
  logic [DATA_W-1:0]    out_rcv;
  logic [DATA_W-1:0]    out_now;
  logic                 out_last;

  cell_ctrl_t           ctrl;
  logic [WAITERS-1:0]   sel;
  logic [WAITERS-1:0]   tok_q;
  logic [WAITERS-1:0]   tok_in_v;
  logic [WAITERS-1:0]   busy_v;
  logic [WAITERS-1:0]   hit_v;
  logic [WAITERS-1:0]   last_v;
  logic [FLAG_BITS-1:0] rcv_v [WAITERS];
  logic [FLAG_BITS-1:0] cm_c [WAITERS+1];
  logic [WAITERS:0]     later_c;
  logic [TASK_SPAN-1:0] busy_pad;

  cmd_t                 cmd;
  logic [FLAG_BITS-1:0] fl;
  logic [TASK_W-1:0]    task_id;
  logic                 wait_all;
  logic                 clr_done;
  logic                 may_block;
  logic                 in_range;
  logic                 accept;
  logic                 out_free;
  logic [FLAG_BITS-1:0] w_masked;
  logic                 w_sat;
  logic                 w_queue;
  logic                 any_hit;
  logic [TASK_W-1:0]    hit_slot;
  logic [FLAG_BITS-1:0] hit_rcv;
  logic                 hit_last;
  logic [FLAG_BITS-1:0] cmask_all;

  // request unpacking
  assign cmd       = cmd_t'(s_tuser);
  assign fl        = FLAG_BITS'(s_tdata[31:0]);
  assign task_id   = s_tdata[34:32];
  assign wait_all  = s_tdata[35];
  assign clr_done  = s_tdata[36];
  assign may_block = s_tdata[37];
  assign in_range  = 32'(task_id) < WAITERS;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  // immediate wait check
  assign w_masked = flag_word & fl;
  assign w_sat    = wait_all ? (w_masked == fl) : (|w_masked);
  assign w_queue  = !w_sat && may_block && in_range;

  // cell controls
  always_comb begin
    ctrl          = '0;
    ctrl.adv      = (state == ST_SCAN) && out_free;
    ctrl.tok_clr  = (state == ST_EVAL);
    ctrl.eval     = (state == ST_EVAL);
    ctrl.wr       = accept && (cmd == CMD_WAIT) && w_queue;
    ctrl.drop     = accept && ((cmd == CMD_WAIT) || (cmd == CMD_TIMEOUT));
    ctrl.word     = flag_word;
    ctrl.mask     = fl;
    ctrl.wait_all = wait_all;
    ctrl.clr_done = clr_done;
  end

  // slot decode
  always_comb begin
    for (int i = 0; i < WAITERS; i++) begin
      sel[i] = in_range && (32'(task_id) == i);
    end
  end

  // row of waiter cells
  assign tok_in_v          = WAITERS'({tok_q, tok_start});
  assign cm_c[0]           = '0;
  assign later_c[WAITERS]  = 1'b0;

  for (genvar i = 0; i < WAITERS; i++) begin : g_cell
    efg_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .sel       (sel[i]),
      .tok_in    (tok_in_v[i]),
      .tok       (tok_q[i]),
      .cmask_in  (cm_c[i]),
      .cmask_out (cm_c[i+1]),
      .later_in  (later_c[i+1]),
      .later_out (later_c[i]),
      .busy      (busy_v[i]),
      .hit       (hit_v[i]),
      .rcv       (rcv_v[i]),
      .last      (last_v[i])
    );
  end

  assign cmask_all = cm_c[WAITERS];
  assign busy_pad  = TASK_SPAN'(busy_v);

  // pick the cell holding the token
  always_comb begin
    any_hit  = |hit_v;
    hit_slot = '0;
    hit_rcv  = '0;
    hit_last = 1'b0;
    for (int i = 0; i < WAITERS; i++) begin
      if (hit_v[i]) begin
        hit_slot = TASK_W'(i);
        hit_rcv  = rcv_v[i];
        hit_last = last_v[i];
      end
    end
  end

  // sequencer, flag word and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      flag_word <= '0;
      tok_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_tready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_SET: begin
                flag_word <= flag_word | fl;
                state     <= ST_EVAL;
              end
              CMD_CLEAR: begin
                flag_word <= flag_word & ~fl;
                out_valid <= 1'b1;
                out_kind  <= KIND_ACK;
                out_slot  <= '0;
                out_rcv   <= '0;
                out_now   <= DATA_W'(flag_word & ~fl);
                out_last  <= 1'b1;
              end
              CMD_WAIT: begin
                out_valid <= 1'b1;
                out_slot  <= task_id;
                out_last  <= 1'b1;
                if (w_sat) begin
                  out_kind <= KIND_OK;
                  out_rcv  <= DATA_W'(w_masked);
                  if (clr_done) begin
                    flag_word <= flag_word & ~w_masked;
                    out_now   <= DATA_W'(flag_word & ~w_masked);
                  end else begin
                    out_now <= DATA_W'(flag_word);
                  end
                end else begin
                  out_kind <= w_queue ? KIND_QUEUED : KIND_TIMEOUT;
                  out_rcv  <= '0;
                  out_now  <= DATA_W'(flag_word);
                end
              end
              default: begin
                out_valid <= 1'b1;
                out_kind  <= (in_range && busy_pad[task_id]) ? KIND_TIMEOUT : KIND_ACK;
                out_slot  <= task_id;
                out_rcv   <= '0;
                out_now   <= DATA_W'(flag_word);
                out_last  <= 1'b1;
              end
            endcase
          end
        end
        ST_EVAL: begin
          state <= ST_CLR;
        end
        ST_CLR: begin
          flag_word <= flag_word & ~cmask_all;
          if (later_c[0]) begin
            tok_start <= 1'b1;
            state     <= ST_SCAN;
          end else begin
            out_valid <= 1'b1;
            out_kind  <= KIND_NONE;
            out_slot  <= '0;
            out_rcv   <= '0;
            out_now   <= DATA_W'(flag_word);
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          if (out_free) begin
            tok_start <= 1'b0;
            if (any_hit) begin
              out_valid <= 1'b1;
              out_kind  <= KIND_WOKEN;
              out_slot  <= hit_slot;
              out_rcv   <= DATA_W'(hit_rcv);
              out_now   <= DATA_W'(flag_word);
              out_last  <= hit_last;
              if (hit_last) state <= ST_IDLE;
            end
          end
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_now, out_rcv, out_slot};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

// File: sv/efg_check.sv
module efg_check import efg_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // only woken results can be followed by more results of the same request
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_WOKEN) |-> m_tlast)
    else $error("single result without tlast");

  // received bits only on satisfied or woken waits
  a_rcv_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_OK && m_tuser != KIND_WOKEN) |-> (m_tdata[34:3] == '0))
    else $error("received bits on a result that delivers none");

  // a set request blocks new requests while waiters are evaluated
  a_set_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == CMD_SET) |=> !s_tready)
    else $error("request taken during set evaluation");

  // stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped while stalled");

endmodule

bind event_flag_group efg_check u_check (.*);
